### design/pbsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_pkg
// Shared types, constants and character helpers for the pileup base parser.
// ----------------------------------------------------------------------------
package pbsp_pkg;

	localparam int InsSlots     = 5;
	localparam int KeepInsert   = 5;
	localparam int KeepLimit    = (KeepInsert < InsSlots) ? KeepInsert : InsSlots;
	localparam int MaxIndelLen  = 1023;
	localparam int RemW         = 10;
	localparam int TokW         = 17;
	localparam int LimW         = 16;
	localparam int CoverageRst  = 64;
	localparam int OutDepth     = 4;
	localparam int OutPtrW      = $clog2(OutDepth);

	localparam logic [7:0] ChCaret = 8'h5E;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpN   = 8'h4E;
	localparam logic [7:0] ChLowN  = 8'h6E;
	localparam logic [7:0] ChDel   = 8'h44;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;

	typedef struct packed {
		logic [7:0]                 read_base;
		logic [2:0]                 insert_length;
		logic [InsSlots-1:0][7:0]   insert_bases;
		logic                       element_valid;
		logic                       parse_error;
		logic                       last_of_line;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} step_out_t;

	function automatic logic is_base(input logic [7:0] c);
		return c inside {8'h41, 8'h43, 8'h47, 8'h54, 8'h4E,
		                 8'h61, 8'h63, 8'h67, 8'h74, 8'h6E};
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= ChLowA && c <= ChLowZ) ? c - 8'd32 : c;
	endfunction

	function automatic logic is_n(input logic [7:0] c);
		return (c == ChUpN) || (c == ChLowN);
	endfunction

endpackage

### design/pileup_base_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_base_string_parser
// Parses the mpileup read-base column byte by byte into per-read elements.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                          | tuser          | tlast
//  s_*     | in  | [7:0] text_byte, [15:8] reference_base | -              | line_end
//  m_*     | out | [7:0] read_base, [10:8] insert_length, | [0] element_valid | last_of_line
//          |     | [50:11] insert_base_0..4, rest zero    | [1] parse_error   |
//  cfg_*   | in  | [15:0] coverage_limit                  | -              | -
//
// One byte accepted per cycle while the result queue has room. A byte's results
// enter the result queue when the byte leaves the input register and are on m_*
// from then on; an element itself only leaves with the next element or the column end.
// A byte that gives two results (end of column behind a held element) needs two
// output slots; sustained rate is bounded by the one-result-per-cycle master port
// and the four-entry result queue, which accepts only with two free slots.
// Reset: all line state cleared, coverage_limit = 64; no clearing pass.
// Master-side stalls back up through the queue to s_tready.
// ----------------------------------------------------------------------------
module pileup_base_string_parser
	import pbsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // text_byte, reference_base
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // read_base, insert_length, insert_base_0..4, pad
	output logic [1:0]  m_tuser,   // element_valid, parse_error
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic            valid_s1, line_end_s1, fire, room;
	logic [15:0]     data_s1;
	logic [LimW-1:0] limit_q;
	step_out_t       step_out;
	result_t         out_res;

	assign fire      = valid_s1 && room;
	assign s_tready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			limit_q  <= LimW'(CoverageRst);
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (cfg_valid)
				limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1     <= s_tdata;
			line_end_s1 <= s_tlast;
		end
	end

	pbsp_parse_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.text_byte      (data_s1[7:0]),
		.reference_base (data_s1[15:8]),
		.line_end       (line_end_s1),
		.coverage_limit (limit_q),
		.step_out       (step_out)
	);

	pbsp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step_out),
		.push_en   (fire),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {5'd0, out_res.insert_bases, out_res.insert_length, out_res.read_base};
	assign m_tuser = {out_res.parse_error, out_res.element_valid};
	assign m_tlast = out_res.last_of_line;

	// a bare result carries no base or insertion
	a_bare_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[50:0] == '0)
		else $error("bare result carries payload");

	// a stalled byte stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(data_s1) && $stable(line_end_s1))
		else $error("input register lost a byte");

	// end of column always produces a final result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && line_end_s1 |-> step_out.cnt != 2'd0 && step_out.r1.last_of_line)
		else $error("column end produced no result");

	// only a column end yields two results
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step_out.cnt == 2'd2 |-> line_end_s1 && !step_out.r0.last_of_line)
		else $error("unexpected second result");

endmodule

### design/pbsp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_parse_core
// Column mode machine with the held element; one byte per fire, up to two
// results out.
// ----------------------------------------------------------------------------
module pbsp_parse_core
	import pbsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       text_byte,
	input  logic [7:0]       reference_base,
	input  logic             line_end,
	input  logic [LimW-1:0]  coverage_limit,
	output step_out_t        step_out
);

	localparam logic [2:0] ModeNormal = 3'd0;
	localparam logic [2:0] ModeCaret  = 3'd1;
	localparam logic [2:0] ModeSign   = 3'd2;
	localparam logic [2:0] ModeDigits = 3'd3;
	localparam logic [2:0] ModeRun    = 3'd4;
	localparam logic [2:0] ModeIgnore = 3'd5;

	logic [2:0]               mode_q, mode_v;
	logic                     is_ins_q, is_ins_v;
	logic [RemW-1:0]          rem_q, rem_v;
	logic [TokW-1:0]          tok_q, tok_v;
	logic                     pv_q, pv_v;
	logic [7:0]               pb_q, pb_v;
	logic [2:0]               plen_q, plen_v;
	logic [InsSlots-1:0][7:0] ins_q, ins_v;

	logic             digit, base_c, over_lim, err, do_norm, do_run, new_el, emit0;
	logic [7:0]       new_b, ins_code, digit_val;
	logic [13:0]      rem_x10;
	result_t          pend_res, end_res, bare_res;

	assign digit     = (text_byte >= ChZero) && (text_byte <= ChNine);
	assign base_c    = is_base(text_byte);
	assign digit_val = text_byte - ChZero;
	assign ins_code  = is_n(text_byte) ? 8'h00 : to_upper(text_byte);
	assign over_lim  = tok_q > {1'b0, coverage_limit};
	assign rem_x10   = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0} + {6'd0, digit_val};

	always_comb begin
		mode_v   = mode_q;
		is_ins_v = is_ins_q;
		rem_v    = rem_q;
		tok_v    = tok_q;
		pv_v     = pv_q;
		pb_v     = pb_q;
		plen_v   = plen_q;
		ins_v    = ins_q;
		err      = 1'b0;
		do_norm  = 1'b0;
		do_run   = 1'b0;
		new_el   = 1'b0;
		new_b    = 8'h00;
		emit0    = 1'b0;
		pend_res = '0;
		end_res  = '0;
		bare_res = '0;

		case (mode_q)
			ModeCaret: mode_v = ModeNormal;
			ModeSign: begin
				if (digit) begin
					rem_v  = RemW'(digit_val);
					mode_v = ModeDigits;
				end else begin
					mode_v  = ModeNormal;
					do_norm = 1'b1;
				end
			end
			ModeDigits: begin
				if (digit) begin
					rem_v = (rem_x10 > 14'(MaxIndelLen)) ? RemW'(MaxIndelLen) : rem_x10[RemW-1:0];
				end else if (base_c) begin
					if (over_lim) begin
						mode_v = ModeIgnore;
					end else begin
						tok_v  = tok_q + 1'b1;
						mode_v = ModeRun;
						if (is_ins_q) begin
							if (!pv_q) begin
								err = 1'b1;
							end else begin
								plen_v = '0;
								ins_v  = '0;
							end
						end
						do_run = 1'b1;
					end
				end else begin
					mode_v  = ModeNormal;
					do_norm = 1'b1;
				end
			end
			ModeRun: begin
				if (base_c) begin
					do_run = 1'b1;
				end else begin
					if (rem_q != '0) begin
						err = 1'b1;
						if (is_ins_q && pv_q) begin
							plen_v = '0;
							ins_v  = '0;
						end
					end
					rem_v   = '0;
					mode_v  = ModeNormal;
					do_norm = 1'b1;
				end
			end
			ModeNormal: do_norm = 1'b1;
			default: ;
		endcase

		if (do_run) begin
			if (rem_v != '0) begin
				rem_v = rem_v - 1'b1;
				if (is_ins_v && pv_v && plen_v < 3'(KeepLimit)) begin
					ins_v[plen_v] = ins_code;
					plen_v        = plen_v + 1'b1;
				end
			end else begin
				new_el = 1'b1;
				new_b  = is_n(text_byte) ? reference_base : to_upper(text_byte);
			end
		end

		if (do_norm) begin
			if (text_byte == ChCaret) begin
				mode_v = ModeCaret;
			end else if (text_byte == ChPlus || text_byte == ChMinus) begin
				is_ins_v = (text_byte == ChPlus);
				mode_v   = ModeSign;
			end else if (text_byte == ChDot || text_byte == ChComma || text_byte == ChStar
			             || base_c) begin
				if (over_lim) begin
					mode_v = ModeIgnore;
				end else begin
					tok_v  = tok_q + 1'b1;
					new_el = 1'b1;
					if (text_byte == ChStar)
						new_b = ChDel;
					else if (text_byte == ChDot || text_byte == ChComma || is_n(text_byte))
						new_b = reference_base;
					else
						new_b = to_upper(text_byte);
				end
			end
		end

		// a new element pushes out the held one
		if (new_el) begin
			if (pv_v) begin
				emit0                  = 1'b1;
				pend_res.read_base     = pb_v;
				pend_res.insert_length = plen_v;
				pend_res.insert_bases  = ins_v;
				pend_res.element_valid = 1'b1;
			end
			pv_v   = 1'b1;
			pb_v   = new_b;
			plen_v = '0;
			ins_v  = '0;
		end

		if (line_end) begin
			if (mode_v == ModeRun && rem_v != '0) begin
				err = 1'b1;
				if (is_ins_v && pv_v) begin
					plen_v = '0;
					ins_v  = '0;
				end
			end
			if (pv_v) begin
				end_res.read_base     = pb_v;
				end_res.insert_length = plen_v;
				end_res.insert_bases  = ins_v;
				end_res.element_valid = 1'b1;
			end
			end_res.last_of_line = 1'b1;
			mode_v   = ModeNormal;
			is_ins_v = 1'b0;
			rem_v    = '0;
			tok_v    = '0;
			pv_v     = 1'b0;
			pb_v     = '0;
			plen_v   = '0;
			ins_v    = '0;
		end

		bare_res.parse_error = 1'b1;

		step_out.cnt = {1'b0, emit0} + {1'b0, line_end};
		step_out.r1  = end_res;
		if (emit0)
			step_out.r0 = pend_res;
		else if (line_end)
			step_out.r0 = end_res;
		else
			step_out.r0 = bare_res;
		if (err) begin
			step_out.r0.parse_error = 1'b1;
			if (!emit0 && !line_end)
				step_out.cnt = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ModeNormal;
			is_ins_q <= 1'b0;
			rem_q    <= '0;
			tok_q    <= '0;
			pv_q     <= 1'b0;
			pb_q     <= '0;
			plen_q   <= '0;
			ins_q    <= '0;
		end else if (fire) begin
			mode_q   <= mode_v;
			is_ins_q <= is_ins_v;
			rem_q    <= rem_v;
			tok_q    <= tok_v;
			pv_q     <= pv_v;
			pb_q     <= pb_v;
			plen_q   <= plen_v;
			ins_q    <= ins_v;
		end
	end

endmodule

### design/pbsp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_out_fifo
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module pbsp_out_fifo
	import pbsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  step_out_t push,
	input  logic      push_en,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_res
);

	result_t                mem_q [OutDepth];
	logic [OutPtrW-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [OutPtrW:0]       cnt_q;
	logic [1:0]             n_push;
	logic                   pop;

	assign n_push    = push_en ? push.cnt : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign room      = cnt_q <= (OutPtrW+1)'(OutDepth - 2);
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_ptr_q] <= push.r0;
		if (n_push == 2'd2)
			mem_q[wr_ptr_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OutPtrW'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (OutPtrW+1)'(n_push) - (OutPtrW+1)'(pop);
		end
	end

endmodule
